// File: hdl/sst_pkg.sv
// sst_pkg: shared types and constants of the sorted tuple table.
// Holds request codes, result status codes, sequencer states and cell control.
// No dependencies.
`timescale 1ns / 1ps

package sst_pkg;

    localparam int SOURCE_BITS = 8;
    localparam int STATUS_BITS = 3;

    localparam logic FUNC_INSERT = 1'b0;
    localparam logic FUNC_DELETE = 1'b1;

    typedef enum logic [STATUS_BITS-1:0] {
        STAT_INSERTED  = 3'd0,
        STAT_DUPLICATE = 3'd1,
        STAT_DELETED   = 3'd2,
        STAT_NOT_FOUND = 3'd3,
        STAT_FULL      = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CMP,
        S_ENC,
        S_UPD
    } state_t;

    typedef enum logic [1:0] {
        OP_HOLD,
        OP_INSERT,
        OP_DELETE
    } cell_op_t;

    typedef struct packed {
        logic     compare;
        cell_op_t op;
    } cell_ctl_t;

endpackage

// File: hdl/sst_cell.sv
// sst_cell: one slot of the sorted tuple chain.
// Compares its tuple with the request and shifts with its neighbors.
// Depends on sst_pkg.
`timescale 1ns / 1ps

module sst_cell import sst_pkg::*; #(
    parameter int IDX        = 0,
    parameter int KEY_BITS   = 16,
    parameter int VALUE_BITS = 32,
    parameter int CNT_BITS   = 7
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  cell_ctl_t              ctl,
    input  logic [CNT_BITS-1:0]    count,
    input  logic [CNT_BITS-1:0]    at,
    input  logic [KEY_BITS-1:0]    req_key,
    input  logic [VALUE_BITS-1:0]  req_value,
    input  logic [SOURCE_BITS-1:0] req_source,
    input  logic [KEY_BITS-1:0]    left_key,
    input  logic [VALUE_BITS-1:0]  left_value,
    input  logic [SOURCE_BITS-1:0] left_source,
    input  logic [KEY_BITS-1:0]    right_key,
    input  logic [VALUE_BITS-1:0]  right_value,
    input  logic [SOURCE_BITS-1:0] right_source,
    output logic [KEY_BITS-1:0]    key,
    output logic [VALUE_BITS-1:0]  value,
    output logic [SOURCE_BITS-1:0] source,
    output logic                   le,
    output logic                   hit
);

    localparam logic [CNT_BITS-1:0] MY_IDX = CNT_BITS'(IDX);

    logic [KEY_BITS-1:0]    key_reg, key_next;
    logic [VALUE_BITS-1:0]  value_reg, value_next;
    logic [SOURCE_BITS-1:0] source_reg, source_next;
    logic                   le_reg, hit_reg;
    logic                   slot_valid;

    assign slot_valid = MY_IDX < count;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            le_reg  <= 1'b0;
            hit_reg <= 1'b0;
        end else if (ctl.compare) begin
            le_reg  <= slot_valid && (key_reg <= req_key);
            hit_reg <= slot_valid && (key_reg == req_key) && (value_reg == req_value)
                       && (source_reg == req_source);
        end
    end

    always_comb begin
        key_next    = key_reg;
        value_next  = value_reg;
        source_next = source_reg;
        unique case (ctl.op)
            OP_HOLD: begin
            end
            OP_INSERT: begin
                if (MY_IDX > at) begin
                    key_next    = left_key;
                    value_next  = left_value;
                    source_next = left_source;
                end else if (MY_IDX == at) begin
                    key_next    = req_key;
                    value_next  = req_value;
                    source_next = req_source;
                end
            end
            OP_DELETE: begin
                if (MY_IDX >= at) begin
                    key_next    = right_key;
                    value_next  = right_value;
                    source_next = right_source;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        key_reg    <= key_next;
        value_reg  <= value_next;
        source_reg <= source_next;
    end

    assign key    = key_reg;
    assign value  = value_reg;
    assign source = source_reg;
    assign le     = le_reg;
    assign hit    = hit_reg;

endmodule

// File: hdl/sst_encoder.sv
// sst_encoder: turns the per-cell compare flags into a table index.
// Picks the matching slot, else the end of the key run.
// Depends on sst_pkg.
`timescale 1ns / 1ps

module sst_encoder import sst_pkg::*; #(
    parameter int TABLE_DEPTH = 64,
    parameter int CNT_BITS    = 7
) (
    input  logic [TABLE_DEPTH-1:0] le_vec,
    input  logic [TABLE_DEPTH-1:0] hit_vec,
    output logic [CNT_BITS-1:0]    at,
    output logic                   found
);

    localparam logic [CNT_BITS-1:0] DEPTH_CNT = CNT_BITS'(TABLE_DEPTH);

    logic [TABLE_DEPTH-1:0] le_prev;
    logic [TABLE_DEPTH-1:0] bnd_vec;
    logic [CNT_BITS-1:0]    hit_idx;
    logic [CNT_BITS-1:0]    bnd_idx;

    assign le_prev = {le_vec[TABLE_DEPTH-2:0], 1'b1};
    assign bnd_vec = le_prev & ~le_vec;

    always_comb begin
        hit_idx = '0;
        bnd_idx = '0;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            if (hit_vec[i]) begin
                hit_idx = hit_idx | CNT_BITS'(i);
            end
            if (bnd_vec[i]) begin
                bnd_idx = bnd_idx | CNT_BITS'(i);
            end
        end
    end

    assign found = |hit_vec;

    always_comb begin
        priority if (found) begin
            at = hit_idx;
        end else if (|bnd_vec) begin
            at = bnd_idx;
        end else begin
            at = DEPTH_CNT;
        end
    end

endmodule

// File: hdl/sorted_tuple_table.sv
// sorted_tuple_table: key-sorted tuple table built as a chain of compare/shift cells.
// Each request passes through the compare, encode and update steps in order before its result is valid.
// A new request is taken only while idle or in the update step of the request before it.
// A waiting result stalls the update step until it is taken.
// Reset: synchronous active-low aresetn empties the table; slot contents stay undefined.
// Depends on sst_pkg, sst_cell, sst_encoder.
`timescale 1ns / 1ps

module sorted_tuple_table import sst_pkg::*; #(
    parameter  int TABLE_DEPTH = 64,
    parameter  int KEY_BITS    = 16,
    parameter  int VALUE_BITS  = 32,
    localparam int CNT_BITS    = $clog2(TABLE_DEPTH + 1)
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic                   s_func,
    input  logic [KEY_BITS-1:0]    s_key_id,
    input  logic [VALUE_BITS-1:0]  s_value_word,
    input  logic [SOURCE_BITS-1:0] s_source_id,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [STATUS_BITS-1:0] m_status,
    output logic [CNT_BITS-1:0]    m_position,
    output logic [CNT_BITS-1:0]    m_occupancy
);

    localparam logic [CNT_BITS-1:0] DEPTH_CNT = CNT_BITS'(TABLE_DEPTH);
    localparam logic [CNT_BITS-1:0] ONE_CNT   = CNT_BITS'(1);

    state_t                 state_reg, state_next;
    logic                   req_func_reg;
    logic [KEY_BITS-1:0]    req_key_reg;
    logic [VALUE_BITS-1:0]  req_value_reg;
    logic [SOURCE_BITS-1:0] req_source_reg;
    logic [CNT_BITS-1:0]    count_reg;
    logic [CNT_BITS-1:0]    at_reg;
    logic [CNT_BITS-1:0]    occ_reg;
    cell_op_t               op_reg;
    status_t                status_reg;
    logic                   m_valid_reg;
    status_t                m_status_reg;
    logic [CNT_BITS-1:0]    m_position_reg;
    logic [CNT_BITS-1:0]    m_occupancy_reg;

    logic                   s_accept;
    logic                   out_free;
    logic                   upd_go;
    cell_ctl_t              ctl;
    status_t                enc_status;
    cell_op_t               enc_op;
    logic [CNT_BITS-1:0]    enc_occ;
    logic [CNT_BITS-1:0]    enc_at;
    logic                   enc_found;

    logic [KEY_BITS-1:0]    cell_key    [TABLE_DEPTH];
    logic [VALUE_BITS-1:0]  cell_value  [TABLE_DEPTH];
    logic [SOURCE_BITS-1:0] cell_source [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] le_vec;
    logic [TABLE_DEPTH-1:0] hit_vec;

    assign out_free = !m_valid_reg || m_ready;
    assign upd_go   = (state_reg == S_UPD) && out_free;
    assign s_accept = s_valid && s_ready;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_accept) begin
                    state_next = S_CMP;
                end
            end
            S_CMP: begin
                state_next = S_ENC;
            end
            S_ENC: begin
                state_next = S_UPD;
            end
            S_UPD: begin
                if (out_free) begin
                    state_next = s_accept ? S_CMP : S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb begin
        s_ready     = (state_reg == S_IDLE) || upd_go;
        ctl.compare = (state_reg == S_CMP);
        ctl.op      = upd_go ? op_reg : OP_HOLD;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // latch request
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            req_func_reg   <= s_func;
            req_key_reg    <= s_key_id;
            req_value_reg  <= s_value_word;
            req_source_reg <= s_source_id;
        end
    end

    sst_encoder #(
        .TABLE_DEPTH(TABLE_DEPTH),
        .CNT_BITS   (CNT_BITS)
    ) u_encoder (
        .le_vec (le_vec),
        .hit_vec(hit_vec),
        .at     (enc_at),
        .found  (enc_found)
    );

    always_comb begin
        enc_status = STAT_NOT_FOUND;
        enc_op     = OP_HOLD;
        enc_occ    = count_reg;
        priority if (req_func_reg == FUNC_INSERT) begin
            priority if (enc_found) begin
                enc_status = STAT_DUPLICATE;
            end else if (count_reg == DEPTH_CNT) begin
                enc_status = STAT_FULL;
            end else begin
                enc_status = STAT_INSERTED;
                enc_op     = OP_INSERT;
                enc_occ    = count_reg + ONE_CNT;
            end
        end else begin
            if (enc_found) begin
                enc_status = STAT_DELETED;
                enc_op     = OP_DELETE;
                enc_occ    = count_reg - ONE_CNT;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            op_reg <= OP_HOLD;
        end else if (state_reg == S_ENC) begin
            op_reg <= enc_op;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == S_ENC) begin
            at_reg     <= enc_at;
            occ_reg    <= enc_occ;
            status_reg <= enc_status;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else if (upd_go) begin
            count_reg   <= occ_reg;
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (upd_go) begin
            m_status_reg    <= status_reg;
            m_position_reg  <= at_reg;
            m_occupancy_reg <= occ_reg;
        end
    end

    genvar g;
    generate
        for (g = 0; g < TABLE_DEPTH; g++) begin : g_cell
            logic [KEY_BITS-1:0]    l_key, r_key;
            logic [VALUE_BITS-1:0]  l_value, r_value;
            logic [SOURCE_BITS-1:0] l_source, r_source;

            if (g == 0) begin : g_left_edge
                assign l_key    = req_key_reg;
                assign l_value  = req_value_reg;
                assign l_source = req_source_reg;
            end else begin : g_left
                assign l_key    = cell_key[g-1];
                assign l_value  = cell_value[g-1];
                assign l_source = cell_source[g-1];
            end

            if (g == TABLE_DEPTH - 1) begin : g_right_edge
                assign r_key    = req_key_reg;
                assign r_value  = req_value_reg;
                assign r_source = req_source_reg;
            end else begin : g_right
                assign r_key    = cell_key[g+1];
                assign r_value  = cell_value[g+1];
                assign r_source = cell_source[g+1];
            end

            sst_cell #(
                .IDX       (g),
                .KEY_BITS  (KEY_BITS),
                .VALUE_BITS(VALUE_BITS),
                .CNT_BITS  (CNT_BITS)
            ) u_cell (
                .aclk        (aclk),
                .aresetn     (aresetn),
                .ctl         (ctl),
                .count       (count_reg),
                .at          (at_reg),
                .req_key     (req_key_reg),
                .req_value   (req_value_reg),
                .req_source  (req_source_reg),
                .left_key    (l_key),
                .left_value  (l_value),
                .left_source (l_source),
                .right_key   (r_key),
                .right_value (r_value),
                .right_source(r_source),
                .key         (cell_key[g]),
                .value       (cell_value[g]),
                .source      (cell_source[g]),
                .le          (le_vec[g]),
                .hit         (hit_vec[g])
            );
        end
    endgenerate

    assign m_valid     = m_valid_reg;
    assign m_status    = m_status_reg;
    assign m_position  = m_position_reg;
    assign m_occupancy = m_occupancy_reg;

`ifndef SYNTH
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= DEPTH_CNT)
        else $error("tuple count exceeds table depth");

    a_result_load: assert property (@(posedge aclk) disable iff (!aresetn)
        upd_go |=> m_valid_reg)
        else $error("update step did not present a result");

    a_single_hit: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_ENC) |-> $onehot0(hit_vec))
        else $error("more than one slot matches the request");

    a_insert_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && (m_status_reg == STAT_INSERTED)) |-> (m_position_reg < m_occupancy_reg))
        else $error("insert position outside occupied range");

    a_delete_cnt: assert property (@(posedge aclk) disable iff (!aresetn)
        (upd_go && (op_reg == OP_DELETE)) |=> (count_reg == $past(count_reg) - ONE_CNT))
        else $error("delete did not shrink the table by one");
`endif

endmodule
